// File: rtl/tlwf_pkg.sv
package tlwf_pkg;

  localparam int WIN_DEPTH = 5;
  localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
  localparam int COL_W     = 11;
  localparam int LIMIT_W   = 10;
  localparam int LINE_W    = 16;

  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_N     = 8'd110;
  localparam logic [7:0] CH_X     = 8'd120;
  localparam logic [7:0] CH_T     = 8'd116;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_ASCII_MAX = 8'd127;

  localparam logic [LIMIT_W-1:0] WRAP_RESET = LIMIT_W'(44);
  localparam logic [LINE_W-1:0]  LINE_MAX   = '1;
  localparam logic [LINE_W-1:0]  LINE_ONE   = LINE_W'(1);

  typedef enum logic [2:0] {
    TK_PASS,
    TK_WIDE,
    TK_CRLF,
    TK_NXT,
    TK_END
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t       kind;
    logic [2:0][7:0] bytes;
  } tok_t;

endpackage

// File: rtl/text_line_wrap_filter.sv
// Text line wrap filter. Bytes enter a five-byte lookahead window; once it is
// full, or after the request marked tlast, tokens are taken from its head and
// queued (four deep) for the output sequencer, which inserts wrap newlines,
// turns the "/nxt/" marker into a newline, passes three high bytes as one
// two-column glyph, drops CR LF and passes all else. Input takes one request
// per cycle unless a flush runs or window and token queue are full. Output
// gives at most one result per cycle when not stalled: a token's bytes in turn
// (none for CR LF), after any wrap newline. A final request flushes the window
// at one token per cycle while the queue has room, then a marker (tuser low,
// tlast high) gives the line total in tdata[23:8]; then a fresh stream starts.
// A wrap_limit write takes effect at the next edge; write it only when idle.
module text_line_wrap_filter
  import tlwf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,   // wrap_limit
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,      // in_byte
  input  logic               in_tlast,      // in_last
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata,     // out_byte, line_total
  output logic               out_tuser,     // out_valid
  output logic               out_tlast      // out_last
);

  tok_t              f_tok, q_tok;
  logic              f_valid, f_ready, q_valid, q_ready;
  logic [7:0]        o_byte;
  logic [LINE_W-1:0] o_line;

  tlwf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .tok_valid (f_valid),
    .tok_ready (f_ready),
    .tok       (f_tok)
  );

  tlwf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_tok   (f_tok),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_tok   (q_tok)
  );

  tlwf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tok_valid   (q_valid),
    .tok_ready   (q_ready),
    .tok         (q_tok),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_byte    (o_byte),
    .out_flag    (out_tuser),
    .out_last    (out_tlast),
    .out_line    (o_line)
  );

  assign out_tdata = {o_line, o_byte};

endmodule

// File: rtl/tlwf_front.sv
module tlwf_front
  import tlwf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       tok_valid,
  input  logic       tok_ready,
  output tok_t       tok
);

  logic [7:0]        win_r   [WIN_DEPTH];
  logic [7:0]        win_nxt [WIN_DEPTH];
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_mid;
  logic              flush_r, flush_nxt;
  logic [FILL_W-1:0] take_k;
  logic              is_nxt, is_wide, is_crlf, is_end;
  logic              tok_go, accept;
  logic [7:0]        shifted [WIN_DEPTH];

  assign is_end  = flush_r && (fill_r == '0);
  assign is_nxt  = (fill_r >= FILL_W'(5)) && win_r[0] == CH_SLASH && win_r[1] == CH_N &&
                   win_r[2] == CH_X && win_r[3] == CH_T && win_r[4] == CH_SLASH;
  assign is_wide = (fill_r >= FILL_W'(3)) && win_r[0] > CH_ASCII_MAX &&
                   win_r[1] > CH_ASCII_MAX && win_r[2] > CH_ASCII_MAX;
  assign is_crlf = (fill_r >= FILL_W'(2)) && win_r[0] == CH_CR && win_r[1] == CH_LF;

  always_comb begin
    tok.bytes[0] = win_r[0];
    tok.bytes[1] = win_r[1];
    tok.bytes[2] = win_r[2];
    if (is_end) begin
      tok.kind = TK_END;
      take_k   = '0;
    end else if (is_nxt) begin
      tok.kind = TK_NXT;
      take_k   = FILL_W'(5);
    end else if (is_wide) begin
      tok.kind = TK_WIDE;
      take_k   = FILL_W'(3);
    end else if (is_crlf) begin
      tok.kind = TK_CRLF;
      take_k   = FILL_W'(2);
    end else begin
      tok.kind = TK_PASS;
      take_k   = FILL_W'(1);
    end
  end

  assign tok_valid = flush_r || (fill_r == FILL_W'(WIN_DEPTH));
  assign tok_go    = tok_valid && tok_ready;
  assign in_ready  = !flush_r && ((fill_r != FILL_W'(WIN_DEPTH)) || tok_ready);
  assign accept    = in_valid && in_ready;

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      shifted[i] = win_r[i];
      case (take_k)
        FILL_W'(1): if (i + 1 < WIN_DEPTH) shifted[i] = win_r[i + 1];
        FILL_W'(2): if (i + 2 < WIN_DEPTH) shifted[i] = win_r[i + 2];
        FILL_W'(3): if (i + 3 < WIN_DEPTH) shifted[i] = win_r[i + 3];
        default:    shifted[i] = win_r[i];
      endcase
    end
  end

  always_comb begin
    fill_mid  = fill_r;
    flush_nxt = flush_r;
    for (int i = 0; i < WIN_DEPTH; i++) win_nxt[i] = win_r[i];
    if (tok_go) begin
      if (is_end) begin
        flush_nxt = 1'b0;
      end else begin
        fill_mid = fill_r - take_k;
        for (int i = 0; i < WIN_DEPTH; i++) win_nxt[i] = shifted[i];
      end
    end
    fill_nxt = fill_mid;
    if (accept) begin
      win_nxt[fill_mid[FILL_W-1:0]] = in_byte;
      fill_nxt = fill_mid + FILL_W'(1);
      if (in_last) flush_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      flush_r <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      flush_r <= flush_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_DEPTH; i++) win_r[i] <= win_nxt[i];
  end

endmodule

// File: rtl/tlwf_queue.sv
module tlwf_queue
  import tlwf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  tok_t wr_tok,
  output logic rd_valid,
  input  logic rd_ready,
  output tok_t rd_tok
);

  tok_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               push, pop;

  assign wr_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_tok   = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wptr_nxt = push ? wptr_r + Q_PTR_W'(1) : wptr_r;
    rptr_nxt = pop  ? rptr_r + Q_PTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + Q_CNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wr_tok;
  end

endmodule

// File: rtl/tlwf_back.sv
module tlwf_back
  import tlwf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  input  logic               tok_valid,
  output logic               tok_ready,
  input  tok_t               tok,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_flag,
  output logic               out_last,
  output logic [LINE_W-1:0]  out_line
);

  logic [LIMIT_W-1:0] limit_r;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt, line_bump;
  tok_t               cur_r, cur_nxt;
  logic               cur_vld_r, cur_vld_nxt;
  logic               wrapped_r, wrapped_nxt;
  logic [1:0]         widx_r, widx_nxt;
  logic               can_emit, done;
  logic               emit;
  logic [7:0]         e_byte, wide_byte;
  logic               e_flag, e_last;
  logic               ovld_r;
  logic [7:0]         obyte_r;
  logic               oflag_r, olast_r;
  logic [LINE_W-1:0]  oline_r;

  assign can_emit  = !ovld_r || out_ready;
  assign line_bump = (line_r != LINE_MAX) ? line_r + LINE_ONE : line_r;

  always_comb begin
    case (widx_r)
      2'd0:    wide_byte = cur_r.bytes[0];
      2'd1:    wide_byte = cur_r.bytes[1];
      default: wide_byte = cur_r.bytes[2];
    endcase
  end

  always_comb begin
    col_nxt     = col_r;
    line_nxt    = line_r;
    wrapped_nxt = wrapped_r;
    widx_nxt    = widx_r;
    emit        = 1'b0;
    e_byte      = CH_LF;
    e_flag      = 1'b1;
    e_last      = 1'b0;
    done        = 1'b0;
    if (cur_vld_r && can_emit) begin
      if (!wrapped_r && cur_r.kind != TK_END && col_r > COL_W'(limit_r)) begin
        emit        = 1'b1;
        col_nxt     = '0;
        line_nxt    = line_bump;
        wrapped_nxt = 1'b1;
      end else begin
        case (cur_r.kind)
          TK_PASS: begin
            emit    = 1'b1;
            e_byte  = cur_r.bytes[0];
            col_nxt = col_r + COL_W'(1);
            done    = 1'b1;
          end
          TK_WIDE: begin
            emit   = 1'b1;
            e_byte = wide_byte;
            if (widx_r == 2'd2) begin
              col_nxt = col_r + COL_W'(2);
              done    = 1'b1;
            end else begin
              widx_nxt = widx_r + 2'd1;
            end
          end
          TK_NXT: begin
            emit     = 1'b1;
            col_nxt  = '0;
            line_nxt = line_bump;
            done     = 1'b1;
          end
          TK_END: begin
            emit     = 1'b1;
            e_byte   = '0;
            e_flag   = 1'b0;
            e_last   = 1'b1;
            col_nxt  = '0;
            line_nxt = LINE_ONE;
            done     = 1'b1;
          end
          default: done = 1'b1;
        endcase
      end
    end
    if (!cur_vld_r || done) begin
      wrapped_nxt = 1'b0;
      widx_nxt    = 2'd0;
    end
  end

  assign tok_ready = !cur_vld_r || done;

  always_comb begin
    cur_vld_nxt = cur_vld_r;
    cur_nxt     = cur_r;
    if (tok_ready) begin
      cur_vld_nxt = tok_valid;
      cur_nxt     = tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= WRAP_RESET;
      col_r     <= '0;
      line_r    <= LINE_ONE;
      cur_vld_r <= 1'b0;
      wrapped_r <= 1'b0;
      widx_r    <= 2'd0;
      ovld_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      col_r     <= col_nxt;
      line_r    <= line_nxt;
      cur_vld_r <= cur_vld_nxt;
      wrapped_r <= wrapped_nxt;
      widx_r    <= widx_nxt;
      if (emit) ovld_r <= 1'b1;
      else if (out_ready) ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      obyte_r <= e_byte;
      oflag_r <= e_flag;
      olast_r <= e_last;
      oline_r <= line_r;
    end
  end

  assign out_valid = ovld_r;
  assign out_byte  = obyte_r;
  assign out_flag  = oflag_r;
  assign out_last  = olast_r;
  assign out_line  = oline_r;

endmodule

// File: tb/sv/text_line_wrap_filter_checker.sv
module text_line_wrap_filter_checker
  import tlwf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [7:0]         in_tdata,      // in_byte
  input  logic               in_tlast,      // in_last
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [23:0]        out_tdata,     // out_byte, line_total
  input  logic               out_tuser,     // out_valid
  input  logic               out_tlast,     // out_last
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [7:0]        text;
    logic              has_byte;
    logic              is_end;
    logic [LINE_W-1:0] line_total;
  } wrap_result_t;

  wrap_result_t       text_due[$];
  logic [7:0]         window_bytes[WIN_DEPTH];
  int                 window_fill;
  logic [COL_W-1:0]   column_pos;
  logic [LINE_W-1:0]  line_num;
  logic [LIMIT_W-1:0] wrap_limit;

  task automatic queue_result(input logic [7:0] text, input logic has_byte,
                              input logic is_end);
    wrap_result_t r;
    r.text       = text;
    r.has_byte   = has_byte;
    r.is_end     = is_end;
    r.line_total = line_num;
    text_due.push_back(r);
  endtask

  task automatic count_line();
    if (line_num != LINE_MAX) line_num = line_num + LINE_ONE;
  endtask

  task automatic drop_head(input int k);
    int i;
    for (i = 0; i + k < WIN_DEPTH; i++) window_bytes[i] = window_bytes[i + k];
    window_fill = window_fill - k;
  endtask

  task automatic take_token();
    if (column_pos > COL_W'(wrap_limit)) begin
      queue_result(CH_LF, 1'b1, 1'b0);
      column_pos = '0;
      count_line();
    end
    if (window_fill >= 5 && window_bytes[0] == CH_SLASH && window_bytes[1] == CH_N &&
        window_bytes[2] == CH_X && window_bytes[3] == CH_T &&
        window_bytes[4] == CH_SLASH) begin
      column_pos = '0;
      queue_result(CH_LF, 1'b1, 1'b0);
      count_line();
      drop_head(5);
    end else if (window_fill >= 3 && window_bytes[0] > CH_ASCII_MAX &&
                 window_bytes[1] > CH_ASCII_MAX && window_bytes[2] > CH_ASCII_MAX) begin
      queue_result(window_bytes[0], 1'b1, 1'b0);
      queue_result(window_bytes[1], 1'b1, 1'b0);
      queue_result(window_bytes[2], 1'b1, 1'b0);
      column_pos = column_pos + COL_W'(2);
      drop_head(3);
    end else if (window_fill >= 2 && window_bytes[0] == CH_CR &&
                 window_bytes[1] == CH_LF) begin
      drop_head(2);
    end else begin
      queue_result(window_bytes[0], 1'b1, 1'b0);
      column_pos = column_pos + COL_W'(1);
      drop_head(1);
    end
  endtask

  task automatic reflow_byte(input logic [7:0] text, input logic is_last);
    if (window_fill < WIN_DEPTH) begin
      window_bytes[window_fill[FILL_W-1:0]] = text;
      window_fill++;
    end
    if (is_last) begin
      while (window_fill > 0) take_token();
      queue_result(8'd0, 1'b0, 1'b1);
      column_pos = '0;
      line_num   = LINE_ONE;
    end else if (window_fill >= WIN_DEPTH) begin
      take_token();
    end
  endtask

  task automatic check_result();
    wrap_result_t want;
    if (text_due.size() == 0) begin
      $display("%0t: unexpected result byte=%0d valid=%0b last=%0b lines=%0d", $time,
               out_tdata[7:0], out_tuser, out_tlast, out_tdata[23:8]);
      fail_count++;
    end else begin
      want = text_due.pop_front();
      if (out_tdata[7:0] !== want.text) begin
        $display("%0t: out_byte expected %0d actual %0d", $time, want.text,
                 out_tdata[7:0]);
        fail_count++;
      end
      if (out_tuser !== want.has_byte) begin
        $display("%0t: out_valid expected %0b actual %0b", $time, want.has_byte,
                 out_tuser);
        fail_count++;
      end
      if (out_tlast !== want.is_end) begin
        $display("%0t: out_last expected %0b actual %0b", $time, want.is_end,
                 out_tlast);
        fail_count++;
      end
      if (out_tdata[23:8] !== want.line_total) begin
        $display("%0t: line_total expected %0d actual %0d", $time, want.line_total,
                 out_tdata[23:8]);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      text_due.delete();
      window_fill = 0;
      column_pos  = '0;
      line_num    = LINE_ONE;
      wrap_limit  = WRAP_RESET;
    end else begin
      if (cfg_wr_en) wrap_limit = cfg_wr_data;
      if (in_tvalid && in_tready) reflow_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_result();
    end
    pending = text_due.size();
  end

endmodule

// File: tb/sv/text_line_wrap_filter_test.sv
module text_line_wrap_filter_test
  import tlwf_pkg::*;
;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 32;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [LIMIT_W-1:0] cfg_wr_data;
  logic               in_tvalid;
  logic               in_tready;
  logic [7:0]         in_tdata;
  logic               in_tlast;
  logic               out_tvalid;
  logic               out_tready;
  logic [23:0]        out_tdata;
  logic               out_tuser;
  logic               out_tlast;

  int         fail_count;
  int         pending;
  int         send_idle_pct;
  int         stall_pct;
  int         hold_cycles;
  int         quiet_cycles;
  logic [7:0] stream_q[$];

  text_line_wrap_filter DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  text_line_wrap_filter_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // hold off the receiver for hold_cycles, else stall at random
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [7:0] marker_byte(input int j);
    case (j)
      0:       return CH_SLASH;
      1:       return CH_N;
      2:       return CH_X;
      3:       return CH_T;
      default: return CH_SLASH;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] text, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= text;
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_stream();
    int i;
    for (i = 0; i < stream_q.size(); i++) send_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  // drain every request before touching the register
  task automatic set_wrap_limit(input logic [LIMIT_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic add_random_token();
    int pick;
    int cut;
    int j;
    pick = $urandom_range(9);
    case (pick)
      0, 1: for (j = 0; j < 5; j++) stream_q.push_back(marker_byte(j));
      2, 3: repeat (3) stream_q.push_back(8'($urandom_range(128, 255)));
      4: begin
        stream_q.push_back(CH_CR);
        stream_q.push_back(CH_LF);
      end
      5: begin
        cut = $urandom_range(1, 4);
        for (j = 0; j < cut; j++) stream_q.push_back(marker_byte(j));
        stream_q.push_back(8'($urandom_range(255)));
      end
      6: begin
        repeat (2) stream_q.push_back(8'($urandom_range(128, 255)));
        stream_q.push_back(8'($urandom_range(127)));
      end
      7: stream_q.push_back($urandom_range(1) ? CH_CR : CH_LF);
      default: stream_q.push_back(8'($urandom_range(255)));
    endcase
  endtask

  initial begin
    int phase;
    int sent;
    logic [LIMIT_W-1:0] limit_val;

    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    stream_q = '{CH_SLASH, CH_N, CH_X, CH_T, CH_SLASH, 8'hFF, 8'h80, 8'hC3, CH_CR, CH_LF,
                 CH_ASCII_MAX, 8'h00, 8'h80, 8'hFF};
    send_stream();

    set_wrap_limit(LIMIT_W'(1));
    stream_q = '{8'h61, 8'h62, 8'hFF, 8'hFF, 8'hFF, 8'h63, CH_CR, CH_LF, 8'h64,
                 CH_SLASH, CH_N, CH_X};
    send_stream();

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       limit_val = '0;
        1:       limit_val = '1;
        2:       limit_val = LIMIT_W'(3);
        3:       limit_val = WRAP_RESET;
        5:       limit_val = LIMIT_W'(2);
        default: limit_val = LIMIT_W'($urandom_range(40));
      endcase
      set_wrap_limit(limit_val);
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 87;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 87;
        end
        default: begin
          send_idle_pct = 32;
          stall_pct     = 32;
        end
      endcase
      if (phase == 0) hold_cycles = HOLD_CYCLES;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        stream_q.delete();
        repeat ($urandom_range(1, 8)) add_random_token();
        send_stream();
        sent += stream_q.size();
      end
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
